// ----- rtl/core/qpd_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// qpd_pkg: shared types and constants of the quoted-printable decoder
// Character codes, the held-escape state, the result group that travels
// from the front end to the back end, and hex digit helpers.
// ============================================================================
package qpd_pkg;

   localparam logic [7:0] CHAR_MARK = 8'h3D;  // '='
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_0    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_9    = 8'h39;  // '9'
   localparam logic [7:0] CHAR_AU   = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_FU   = 8'h46;  // 'F'
   localparam logic [7:0] CHAR_AL   = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_FL   = 8'h66;  // 'f'
   localparam logic [7:0] HEX_TEN   = 8'd10;

   localparam int unsigned GROUP_MAX = 3;

   // What the front end holds of an unfinished escape sequence.
   typedef enum logic [1:0] {
      HELD_NONE = 2'd0,
      HELD_MARK = 2'd1,
      HELD_PAIR = 2'd2
   } held_type;

   // All results caused by one input transaction.
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] bytes;
      logic [1:0]                last_idx;   // index of the final result
      logic                      has_byte;   // 0 only for a bare end marker
      logic                      stream_end; // group closes the text
   } group_type;

   function automatic logic hex_ok(input logic [7:0] c);
      return ((c >= CHAR_0) && (c <= CHAR_9)) ||
             ((c >= CHAR_AU) && (c <= CHAR_FU)) ||
             ((c >= CHAR_AL) && (c <= CHAR_FL));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         d = c - CHAR_0;
      end else if ((c >= CHAR_AU) && (c <= CHAR_FU)) begin
         d = c - CHAR_AU + HEX_TEN;
      end else if ((c >= CHAR_AL) && (c <= CHAR_FL)) begin
         d = c - CHAR_AL + HEX_TEN;
      end else begin
         d = 8'd0;
      end
      return d[3:0];
   endfunction

endpackage

// ----- rtl/core/qpd_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// qpd_front: escape classifier
// Tracks the held escape mark and byte, and turns each accepted input
// transaction into a group of up to three results.
// ============================================================================
module qpd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               stream_last,
   output logic               push,
   output qpd_pkg::group_type group
);
   import qpd_pkg::*;

   held_type   held_ff, held_in, mid_held;
   logic [7:0] hb_ff, hb_in, mid_hb;
   logic [1:0] n;
   logic [GROUP_MAX-1:0][7:0] b;

   // Next state: first the escape decision, then the flush at stream end.
   always_comb begin
      mid_held = held_ff;
      mid_hb   = hb_ff;
      case (held_ff)
         HELD_PAIR: begin
            mid_held = HELD_NONE;
            mid_hb   = 8'd0;
            if ((hb_ff == CHAR_CR) && (in_byte == CHAR_LF)) begin
               mid_held = HELD_NONE;
            end else if (hb_ff == CHAR_LF) begin
               if (in_byte == CHAR_MARK) mid_held = HELD_MARK;
            end else if (hex_ok(hb_ff) && hex_ok(in_byte)) begin
               mid_held = HELD_NONE;
            end else if (hb_ff == CHAR_MARK) begin
               mid_held = HELD_PAIR;
               mid_hb   = in_byte;
            end else if (in_byte == CHAR_MARK) begin
               mid_held = HELD_MARK;
            end
         end
         HELD_MARK: begin
            mid_held = HELD_PAIR;
            mid_hb   = in_byte;
         end
         default: begin
            mid_held = (in_byte == CHAR_MARK) ? HELD_MARK : HELD_NONE;
         end
      endcase
      held_in = stream_last ? HELD_NONE : mid_held;
      hb_in   = stream_last ? 8'd0 : mid_hb;
   end

   // Results of the transaction.
   always_comb begin
      b = '0;
      n = 2'd0;
      case (held_ff)
         HELD_PAIR: begin
            if ((hb_ff == CHAR_CR) && (in_byte == CHAR_LF)) begin
               n = 2'd0;
            end else if (hb_ff == CHAR_LF) begin
               if (in_byte != CHAR_MARK) begin
                  b[0] = in_byte;
                  n    = 2'd1;
               end
            end else if (hex_ok(hb_ff) && hex_ok(in_byte)) begin
               b[0] = {hex_val(hb_ff), hex_val(in_byte)};
               n    = 2'd1;
            end else begin
               b[0] = CHAR_MARK;
               if (hb_ff == CHAR_MARK) begin
                  n = 2'd1;
               end else begin
                  b[1] = hb_ff;
                  if (in_byte == CHAR_MARK) begin
                     n = 2'd2;
                  end else begin
                     b[2] = in_byte;
                     n    = 2'd3;
                  end
               end
            end
         end
         HELD_MARK: begin
            n = 2'd0;
         end
         default: begin
            if (in_byte != CHAR_MARK) begin
               b[0] = in_byte;
               n    = 2'd1;
            end
         end
      endcase
      // At stream end the held mark and byte pass literally.
      if (stream_last && (mid_held != HELD_NONE)) begin
         b[n] = CHAR_MARK;
         n    = n + 2'd1;
         if (mid_held == HELD_PAIR) begin
            b[n] = mid_hb;
            n    = n + 2'd1;
         end
      end
      group.bytes      = b;
      group.has_byte   = (n != 2'd0);
      group.last_idx   = (n != 2'd0) ? (n - 2'd1) : 2'd0;
      group.stream_end = stream_last;
      push             = accept && (stream_last || (n != 2'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
         hb_ff   <= 8'd0;
      end else if (accept) begin
         held_ff <= held_in;
         hb_ff   <= hb_in;
      end
   end

   // A transaction that ends the text leaves nothing held.
   assert property (@(posedge clock) disable iff (reset)
      accept && stream_last |=> held_ff == HELD_NONE)
      else $error("qpd_front: escape state survived stream end");

endmodule

// ----- rtl/core/qpd_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// qpd_queue: result group queue
// Short first-in first-out store of result groups between the front end
// and the back end.
// ============================================================================
module qpd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qpd_pkg::group_type push_data,
   input  logic               pop,
   output qpd_pkg::group_type head,
   output logic               empty,
   output logic               full
);
   import qpd_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   group_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CW'(DEPTH));
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? bump(wr_ff) : wr_ff;
      rd_in  = pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("qpd_queue: push into full queue");

   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("qpd_queue: pop from empty queue");

endmodule

// ----- rtl/core/qpd_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// qpd_back: result serializer
// Takes one result group at a time from the queue and hands its results
// out one per cycle while rsp_stall is low, from a registered group.
// ============================================================================
module qpd_back (
   input  logic               clock,
   input  logic               reset,
   input  qpd_pkg::group_type head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_has_byte,
   output logic               rsp_run_last,
   output logic               rsp_stream_end
);
   import qpd_pkg::*;

   group_type  grp_ff, grp_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       take, done;

   always_comb begin
      take    = busy_ff && !rsp_stall;
      done    = take && (idx_ff == grp_ff.last_idx);
      pop     = (!busy_ff || done) && !empty;
      grp_in  = pop ? head : grp_ff;
      busy_in = pop || (busy_ff && !done);
      idx_in  = pop ? 2'd0 : (take ? idx_ff + 2'd1 : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_out_byte   = grp_ff.bytes[idx_ff];
   assign rsp_has_byte   = grp_ff.has_byte;
   assign rsp_run_last   = (idx_ff == grp_ff.last_idx);
   assign rsp_stream_end = grp_ff.stream_end && (idx_ff == grp_ff.last_idx);

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= grp_ff.last_idx) && (grp_ff.last_idx != 2'd3))
      else $error("qpd_back: result index past end of group");

endmodule

// ----- rtl/core/quoted_printable_decoder_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// quoted_printable_decoder_unit: streaming quoted-printable decoder
// Decodes encoded text arriving one byte per transaction into raw bytes.
// ============================================================================
//
// The unit takes one encoded byte per cycle on the req_ channel while
// req_stall is low and returns decoded bytes on the rsp_ channel, one
// result per cycle while rsp_stall is low. An escape mark is held with up
// to two following bytes until it can be resolved: a mark and CR LF (soft
// break) disappear, a mark and LF are dropped and the next byte is handled
// afresh, a mark and two hex digits of either case become one byte, and
// any other mark passes literally. When req_stream_last is set the held
// bytes are flushed literally; if that transaction gives nothing, a single
// result with rsp_has_byte low marks the end. rsp_run_last flags the final
// result of each input transaction and rsp_stream_end the final result of
// the text. One input transaction enters per cycle while the queue is not
// full; each causes zero to three results, and the output port carries one
// result per cycle while rsp_stall is low, so over time the input rate
// follows the number of results each transaction causes. The group queue
// between the classifier and the serializer (QUEUE_DEPTH groups) absorbs
// bursts; req_stall rises only while it is full.
//
module quoted_printable_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_end
);
   import qpd_pkg::*;

   logic      accept;
   logic      push, pop, empty, full;
   group_type push_group, head_group;

   // The front end stalls only on a full queue, never on the output side.
   assign req_stall = full;
   assign accept    = req_valid && !full;

   // Classifier: holds the escape state and builds one group per transaction.
   qpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .stream_last (req_stream_last),
      .push        (push),
      .group       (push_group)
   );

   // Groups wait here so that the front and back ends stall independently.
   qpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_group),
      .pop       (pop),
      .head      (head_group),
      .empty     (empty),
      .full      (full)
   );

   // Serializer: one result per cycle unless stalled, from a registered group.
   qpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head_group),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

   // A bare end marker is always the last result of its transaction and
   // closes the text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_run_last && rsp_stream_end)
      else $error("quoted_printable_decoder_unit: stray end marker");

endmodule
